// ===== rtl/ntm_pkg.sv =====
`timescale 1ns / 1ps

package ntm_pkg;

    typedef logic [7:0] pixel_t;

    typedef struct packed {
        pixel_t above;
        pixel_t center;
        pixel_t below;
    } column_t;

    // one pending mask computation: center column with its two neighbors
    typedef struct packed {
        column_t left;
        column_t mid;
        column_t right;
        logic    last;
    } job_t;

    typedef struct packed {
        logic [2:0] filter_type;
        logic       horiz_halve;
        logic [1:0] vert_scale;
    } ntm_cfg_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_TYPE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HORIZ_HALVE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERT_SCALE  = 2'd2;

    localparam logic [2:0] MODE_HV_AXIS = 3'd0;
    localparam logic [2:0] MODE_HV_DIAG = 3'd1;
    localparam logic [2:0] MODE_DEV4    = 3'd2;
    localparam logic [2:0] MODE_DEV8    = 3'd3;
    localparam logic [2:0] MODE_RANGE5  = 3'd4;
    localparam logic [2:0] MODE_RANGE9  = 3'd5;

    localparam logic [1:0] VSCALE_NONE    = 2'd0;
    localparam logic [1:0] VSCALE_HALF    = 2'd1;
    localparam logic [1:0] VSCALE_QUARTER = 2'd2;

    localparam logic [2:0] FILTER_TYPE_RST = MODE_HV_AXIS;
    localparam logic       HORIZ_HALVE_RST = 1'b0;
    localparam logic [1:0] VERT_SCALE_RST  = VSCALE_HALF;

    localparam int JOB_DEPTH_DEF = 4;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

endpackage

// ===== rtl/ntm_thresh.sv =====
`timescale 1ns / 1ps

module ntm_thresh
    import ntm_pkg::*;
(
    input  job_t     job,
    input  ntm_cfg_t cfg,
    output pixel_t   at
);

    function automatic pixel_t min8(input pixel_t a, input pixel_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pixel_t max8(input pixel_t a, input pixel_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pixel_t adiff(input pixel_t a, input pixel_t b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic pixel_t half_up(input pixel_t v);
        logic [8:0] s;
        s = {1'b0, v} + 9'd1;
        return s[8:1];
    endfunction

    pixel_t ul, l, dl, u, c, d, ur, r, dr;
    pixel_t vmin, vmax, hmin, hmax, gmin, gmax, pmin, pmax;
    pixel_t vlo, vhi, va, vb, ha, hb, part_v, part_h;

    always_comb begin
        ul = job.left.above;  l = job.left.center;  dl = job.left.below;
        u  = job.mid.above;   c = job.mid.center;   d  = job.mid.below;
        ur = job.right.above; r = job.right.center; dr = job.right.below;

        vmin = min8(u, d);
        vmax = max8(u, d);
        hmin = min8(l, r);
        hmax = max8(l, r);
        gmin = min8(min8(ul, ur), min8(dl, dr));
        gmax = max8(max8(ul, ur), max8(dl, dr));
        pmin = min8(vmin, hmin);
        pmax = max8(vmax, hmax);

        vlo = (cfg.filter_type == MODE_HV_DIAG) ? min8(vmin, gmin) : vmin;
        vhi = (cfg.filter_type == MODE_HV_DIAG) ? max8(vmax, gmax) : vmax;
        va  = adiff(vlo, c);
        vb  = adiff(vhi, c);
        ha  = adiff(hmin, c);
        hb  = adiff(hmax, c);

        case (cfg.vert_scale)
            VSCALE_HALF:    part_v = max8(half_up(va), half_up(vb));
            VSCALE_QUARTER: part_v = max8(va >> 2, vb >> 2);
            default:        part_v = max8(va, vb);
        endcase
        part_h = cfg.horiz_halve ? max8(half_up(ha), half_up(hb)) : max8(ha, hb);

        case (cfg.filter_type)
            MODE_HV_AXIS, MODE_HV_DIAG: at = max8(part_v, part_h);
            MODE_DEV4:   at = max8(adiff(pmin, c), adiff(pmax, c));
            MODE_DEV8:   at = max8(adiff(min8(pmin, gmin), c), adiff(max8(pmax, gmax), c));
            MODE_RANGE5: at = max8(pmax, c) - min8(pmin, c);
            default:     at = max8(max8(pmax, gmax), c) - min8(min8(pmin, gmin), c);
        endcase
    end

endmodule

// ===== rtl/neighborhood_threshold_mask_3x3.sv =====
`timescale 1ns / 1ps
// A completed window's job enters the job queue on accept and the output register when popped.
// Throughput: one column per cycle while s_tready is high; a row end adds a second result,
// absorbed by the JOB_DEPTH entry job queue, drained while the next row's first column yields none.
// Reset (aresetn low, synchronous): clears column history, row position, job queue
// and output valid; registers return to mode 0, no horizontal halving, vertical half.

module neighborhood_threshold_mask_3x3
    import ntm_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // pixel_above, pixel_center, pixel_below
    input  logic                   s_tlast,   // row_end
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // quarter_mask[5:0], half_mask[13:6], zero pad
    output logic                   m_tlast    // row_last
);

    localparam int PTR_W = $clog2(JOB_DEPTH);
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    typedef enum logic [2:0] {
        ROW_START = 3'b001,
        ONE_COL   = 3'b010,
        STREAM    = 3'b100
    } row_state_t;

    ntm_cfg_t   cfg_reg;
    row_state_t state_reg, state_next;
    column_t    left_reg, left_next, mid_reg, mid_next, col_in;

    job_t       job_mem [JOB_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    job_t       job_first, job_second;
    logic [1:0] push_cnt;
    logic       accept, pop;
    pixel_t     at;

    logic                 m_tvalid_reg;
    logic [5:0]           quarter_reg;
    pixel_t               half_reg;
    logic                 last_reg;
    logic [8:0]           at_plus;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_type <= FILTER_TYPE_RST;
            cfg_reg.horiz_halve <= HORIZ_HALVE_RST;
            cfg_reg.vert_scale  <= VERT_SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FILTER_TYPE: cfg_reg.filter_type <= cfg_wdata[2:0];
                REG_HORIZ_HALVE: cfg_reg.horiz_halve <= cfg_wdata[0];
                REG_VERT_SCALE:  cfg_reg.vert_scale  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    assign col_in   = '{above: s_tdata[7:0], center: s_tdata[15:8], below: s_tdata[23:16]};
    assign s_tready = aresetn && (count_reg <= CNT_W'(JOB_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;

    // window sequencing: up to two jobs per request
    always_comb begin
        state_next = state_reg;
        left_next  = left_reg;
        mid_next   = mid_reg;
        job_first  = '{left: left_reg, mid: mid_reg, right: col_in, last: 1'b0};
        job_second = '{left: mid_reg, mid: col_in, right: mid_reg, last: 1'b1};
        push_cnt   = 2'd0;
        if (accept) begin
            case (state_reg)
                ROW_START: begin
                    mid_next  = col_in;
                    job_first = '{left: col_in, mid: col_in, right: col_in, last: 1'b1};
                    if (s_tlast) begin
                        push_cnt = 2'd1;
                    end else begin
                        state_next = ONE_COL;
                    end
                end
                ONE_COL, STREAM: begin
                    if (state_reg == ONE_COL) begin
                        job_first.left = col_in;
                    end
                    left_next  = mid_reg;
                    mid_next   = col_in;
                    state_next = s_tlast ? ROW_START : STREAM;
                    push_cnt   = s_tlast ? 2'd2 : 2'd1;
                end
                default: state_next = ROW_START;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ROW_START;
            left_reg  <= '0;
            mid_reg   <= '0;
        end else begin
            state_reg <= state_next;
            left_reg  <= left_next;
            mid_reg   <= mid_next;
        end
    end

    // job queue
    assign pop = (count_reg != '0) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            job_mem[wr_ptr_reg] <= job_first;
        end
        if (push_cnt == 2'd2) begin
            job_mem[wr_ptr_reg + PTR_W'(1)] <= job_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
        end
    end

    ntm_thresh u_thresh (
        .job (job_mem[rd_ptr_reg]),
        .cfg (cfg_reg),
        .at  (at)
    );

    assign at_plus = {1'b0, at} + 9'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pop) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            quarter_reg <= at[7:2];
            half_reg    <= at_plus[8:1];
            last_reg    <= job_mem[rd_ptr_reg].last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, half_reg, quarter_reg};
    assign m_tlast  = last_reg;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(JOB_DEPTH))
        else $error("job queue overflow");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> count_reg == $past(count_reg) + CNT_W'($past(push_cnt))
                                        - CNT_W'($past(pop)))
        else $error("job count mismatch");

    a_row_end_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> state_reg == ROW_START)
        else $error("row end did not restart row");

    a_row_end_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast && state_reg != ROW_START) |-> push_cnt == 2'd2)
        else $error("row end missing trailing result");

endmodule
